// ===== rtl/doubly_linked_list_manager_core_defines.svh =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_core_defines.svh
// Assertion macros used by the list manager checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_MANAGER_CORE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_MANAGER_CORE_DEFINES_SVH

// Concurrent check, masked while reset is asserted.
`define DLLM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dllm check failed");

// Concurrent check that also runs across reset.
`define DLLM_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dllm reset check failed");

`endif

// ===== rtl/dllm_pkg.sv =====
// ----------------------------------------------------------------------------
// dllm_pkg
// Field widths, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dllm_pkg;

    localparam int OP_W     = 2;
    localparam int NODE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTLISTED = 2'd3;

    typedef struct packed {
        logic load;     // request transfer: latch fields, read tables
        logic clear;    // one step of the membership clearing sweep
        logic commit;   // update tables and pointers, load result
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;   // sweep sits on the last entry
    } t_dp_sts;

endpackage

// ===== rtl/dllm_ifs.sv =====
// ----------------------------------------------------------------------------
// dllm_ifs
// Valid/ready channels for list requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dllm_req_if;
    logic                          valid;
    logic                          ready;
    logic [dllm_pkg::OP_W-1:0]     operation;
    logic [dllm_pkg::NODE_W-1:0]   node;

    modport source (output valid, output operation, output node, input ready);
    modport sink   (input valid, input operation, input node, output ready);
endinterface

interface dllm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dllm_pkg::NODE_W-1:0]   popped_node;
    logic                          popped_valid;
    logic [dllm_pkg::COUNT_W-1:0]  item_count;
    logic [dllm_pkg::STATUS_W-1:0] status;

    modport source (output valid, output popped_node, output popped_valid,
                    output item_count, output status, input ready);
    modport sink   (input valid, input popped_node, input popped_valid,
                    input item_count, input status, output ready);
endinterface

// ===== rtl/dllm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dllm_ctrl
// Sequencer: clearing sweep, request accept, execute, result register valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dllm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dllm_pkg::t_dp_cmd o_cmd,
    input  dllm_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = i_in_valid && o_in_ready;
        // execute only when the result register is free or drains now
        o_cmd.commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.load) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (o_cmd.commit) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit)     n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/dllm_datapath.sv =====
// ----------------------------------------------------------------------------
// dllm_datapath
// Link tables, membership table, head/tail/count and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dllm_datapath #(
    parameter int POOL_NODES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dllm_pkg::t_dp_cmd             i_cmd,
    output dllm_pkg::t_dp_sts             o_sts,
    input  logic [dllm_pkg::OP_W-1:0]     i_operation,
    input  logic [dllm_pkg::NODE_W-1:0]   i_node,
    output logic [dllm_pkg::NODE_W-1:0]   o_popped_node,
    output logic                          o_popped_valid,
    output logic [dllm_pkg::COUNT_W-1:0]  o_item_count,
    output logic [dllm_pkg::STATUS_W-1:0] o_status
);

    localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NONE = LW'(POOL_NODES);

    // link tables: undefined until written; member table swept after reset
    logic [LW-1:0] mem_next   [POOL_NODES];
    logic [LW-1:0] mem_prev   [POOL_NODES];
    logic          mem_member [POOL_NODES];

    logic [dllm_pkg::OP_W-1:0] r_op;
    logic [IW-1:0]             r_addr;
    logic                      r_in_pool;
    logic [LW-1:0]             r_rd_next, r_rd_prev;
    logic                      r_rd_mem;
    logic [LW-1:0]             r_head, r_tail, r_count;
    logic [LW-1:0]             n_head, n_tail, n_count;
    logic [IW-1:0]             r_clr_addr;

    logic [31:0]   node_ext, head_ext, count_ext;
    logic [IW-1:0] node_idx, rd_addr;
    logic          in_pool;

    always_comb begin
        node_ext = 32'(i_node);
        node_idx = node_ext[IW-1:0];
        in_pool  = node_ext < 32'(POOL_NODES);
        rd_addr  = (i_operation == dllm_pkg::OP_POP) ? r_head[IW-1:0] : node_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_addr    <= rd_addr;
            r_in_pool <= in_pool;
            r_rd_next <= mem_next[rd_addr];
            r_rd_prev <= mem_prev[rd_addr];
            r_rd_mem  <= mem_member[rd_addr];
        end
    end

    // execute
    logic [LW-1:0]               tgt, nx, pv;
    logic                        appnd, unlink, pop_ok;
    logic [dllm_pkg::STATUS_W-1:0] st;
    logic                        wn_en, wp_en, wm_en;
    logic [IW-1:0]               wn_addr, wp_addr;
    logic [LW-1:0]               wn_data, wp_data;

    always_comb begin
        tgt = LW'(r_addr);
        // end nodes take their outer link from head/tail, not the table
        nx  = (tgt == r_tail) ? NONE : r_rd_next;
        pv  = (tgt == r_head) ? NONE : r_rd_prev;

        st     = dllm_pkg::ST_OK;
        appnd  = 1'b0;
        unlink = 1'b0;
        pop_ok = 1'b0;
        case (r_op)
            dllm_pkg::OP_APPEND: begin
                if (!r_in_pool)    st = dllm_pkg::ST_NOTLISTED;
                else if (r_rd_mem) st = dllm_pkg::ST_LISTED;
                else               appnd = 1'b1;
            end
            dllm_pkg::OP_REMOVE: begin
                if (!r_in_pool || !r_rd_mem) st = dllm_pkg::ST_NOTLISTED;
                else                         unlink = 1'b1;
            end
            dllm_pkg::OP_POP: begin
                if (r_count == '0 || r_head == NONE) begin
                    st = dllm_pkg::ST_EMPTY;
                end else begin
                    unlink = 1'b1;
                    pop_ok = 1'b1;
                end
            end
            default: ;
        endcase

        wn_en   = (appnd && r_tail != NONE) || (unlink && pv != NONE);
        wn_addr = appnd ? r_tail[IW-1:0] : pv[IW-1:0];
        wn_data = appnd ? tgt : nx;
        wp_en   = appnd || (unlink && nx != NONE);
        wp_addr = appnd ? r_addr : nx[IW-1:0];
        wp_data = appnd ? r_tail : pv;
        wm_en   = appnd || unlink;

        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (appnd) begin
            if (r_tail == NONE) n_head = tgt;
            n_tail  = tgt;
            n_count = r_count + LW'(1);
        end else if (unlink) begin
            if (pv == NONE) n_head = nx;
            if (nx == NONE) n_tail = pv;
            n_count = r_count - LW'(1);
        end

        head_ext  = 32'(r_head);
        count_ext = 32'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wn_en) mem_next[wn_addr] <= wn_data;
        if (i_cmd.commit && wp_en) mem_prev[wp_addr] <= wp_data;
        if (i_cmd.clear)                mem_member[r_clr_addr] <= 1'b0;
        else if (i_cmd.commit && wm_en) mem_member[r_addr]     <= appnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= NONE;
            r_tail     <= NONE;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + IW'(1);
            if (i_cmd.commit) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    assign o_sts.clear_last = (r_clr_addr == IW'(POOL_NODES - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_popped_node  <= pop_ok ? head_ext[dllm_pkg::NODE_W-1:0] : '0;
            o_popped_valid <= pop_ok;
            o_item_count   <= count_ext[dllm_pkg::COUNT_W-1:0];
            o_status       <= st;
        end
    end

endmodule

// ===== rtl/doubly_linked_list_manager_core.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_core
// Doubly linked list over a fixed node pool: append, remove, pop head.
// ----------------------------------------------------------------------------
//  channel  dir  signals                                            transfer
//  i_req    in   operation[1:0] node[5:0]                           valid&ready
//  o_rsp    out  popped_node[5:0] popped_valid item_count[6:0]      valid&ready
//                status[1:0]
//
//  Each item passes an accept step (table read issued), then an execute step
//  (tables, head/tail/count and result register written). The registered read
//  of the link and membership tables makes these separate steps; a new request
//  is not accepted until the last one has executed. After reset a clearing pass
//  over every entry zeroes the membership table; i_req.ready stays low meanwhile.
//  A result waiting in o_rsp does not block accepting the next request; the
//  execute step waits only while the result register is full and not draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubly_linked_list_manager_core #(
    parameter int POOL_NODES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dllm_req_if.sink        i_req,
    dllm_rsp_if.source      o_rsp
);

    dllm_pkg::t_dp_cmd cmd;
    dllm_pkg::t_dp_sts sts;

    // sequencer: owns ready, result valid and the command strobes
    dllm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // tables, list pointers and result register
    dllm_datapath #(
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_req.operation),
        .i_node         (i_req.node),
        .o_popped_node  (o_rsp.popped_node),
        .o_popped_valid (o_rsp.popped_valid),
        .o_item_count   (o_rsp.item_count),
        .o_status       (o_rsp.status)
    );

endmodule

// ===== rtl/dllm_checker.sv =====
// ----------------------------------------------------------------------------
// dllm_checker
// Port-level checks on the list manager, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "doubly_linked_list_manager_core_defines.svh"

module dllm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [dllm_pkg::NODE_W-1:0]   i_popped_node,
    input logic                          i_popped_valid,
    input logic [dllm_pkg::COUNT_W-1:0]  i_item_count,
    input logic [dllm_pkg::STATUS_W-1:0] i_status
);

    // clearing pass follows reset
    `DLLM_ASSERT_RST(a_clear_after_rst, i_clk, !i_rst_n |=> !i_req_ready)

    // one item in flight: no accept in the cycle after an accept
    `DLLM_ASSERT(a_one_in_flight, i_clk, i_rst_n,
        (i_req_valid && i_req_ready) |=> !i_req_ready)

    // a returned node only comes with ok status
    `DLLM_ASSERT(a_pop_ok, i_clk, i_rst_n,
        (i_rsp_valid && i_popped_valid) |-> (i_status == dllm_pkg::ST_OK))

    // empty pop leaves an empty list and no node
    `DLLM_ASSERT(a_pop_empty, i_clk, i_rst_n,
        (i_rsp_valid && i_status == dllm_pkg::ST_EMPTY) |->
            (i_item_count == '0 && !i_popped_valid && i_popped_node == '0))

    // stalled result holds
    `DLLM_ASSERT(a_rsp_hold, i_clk, i_rst_n,
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_item_count)))

endmodule

bind doubly_linked_list_manager_core dllm_checker u_dllm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_popped_node  (o_rsp.popped_node),
    .i_popped_valid (o_rsp.popped_valid),
    .i_item_count   (o_rsp.item_count),
    .i_status       (o_rsp.status)
);
